/* rtl/lz77bw_pkg.sv */
package lz77bw_pkg;

   localparam int HistoryDepthDef = 512;
   localparam int OutLanesDef = 8;
   localparam int DistW = 10;

   localparam logic [7:0] VersionByte = 8'h03;
   localparam logic [8:0] MinMatch = 9'd3;

   typedef enum logic [2:0] {
      PH_VERSION,
      PH_SIZE,
      PH_FLAG,
      PH_LITERAL,
      PH_MLEN,
      PH_MOFF,
      PH_COPY,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_VERSION,
      ST_BAD_REF,
      ST_OVERRUN
   } status_type;

   // load starts a finished item, append adds one byte to the item being packed
   typedef struct packed {
      logic       load;
      logic       append;
      logic       has_byte;
      logic       final_item;
      logic       done;
      status_type status;
      logic [7:0] data;
   } pack_cmd_type;

endpackage

/* rtl/lz77bw_req_if.sv */
interface lz77bw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

/* rtl/lz77bw_rsp_if.sv */
interface lz77bw_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_bytes;
   logic [3:0]  byte_count;
   logic [1:0]  status;
   logic        stream_done;
   logic        run_last;

   modport source (output valid, output out_bytes, output byte_count, output status,
                   output stream_done, output run_last, input ready);
   modport sink (input valid, input out_bytes, input byte_count, input status,
                 input stream_done, input run_last, output ready);
endinterface

/* rtl/lz77_byte_window_decompressor_unit.sv */
// channel  | role   | item
// req_if   | sink   | in_byte: one compressed stream byte
// rsp_if   | source | out_bytes, byte_count, status, stream_done, run_last
//
// header, flag, length, offset and literal bytes are accepted back to back while the packing register is ready.
// a match holds req_if off while it copies: one history read per byte, with the
// registered memory read port setting the pace and a full packing register stalling it.
// results pass a packing register and an output register, so one result may
// wait on rsp_if while the next is built; a full packing register stalls input.
// reset clears control state only; history contents are not cleared.
module lz77_byte_window_decompressor_unit #(
   parameter int HISTORY_DEPTH = lz77bw_pkg::HistoryDepthDef,
   parameter int OUT_LANES = lz77bw_pkg::OutLanesDef
) (
   input logic          clock,
   input logic          reset,
   lz77bw_req_if.sink   req_if,
   lz77bw_rsp_if.source rsp_if
);

   localparam int PtrW = $clog2(HISTORY_DEPTH);
   localparam int CntW = $clog2(HISTORY_DEPTH + 1);
   localparam int CmpW = (CntW > lz77bw_pkg::DistW) ? CntW : lz77bw_pkg::DistW;

   lz77bw_pkg::phase_type  phase_ff, phase_in;
   logic [23:0]            rem_ff, rem_in;
   logic [7:0]             lit_ff, lit_in;
   logic [8:0]             mlen_ff, mlen_in;
   logic [PtrW-1:0]        hp_ff, hp_in;
   logic [CntW-1:0]        bw_ff, bw_in;
   logic [PtrW-1:0]        src_ff, src_in;
   logic [8:0]             issue_left_ff, issue_left_in;
   logic [8:0]             append_left_ff, append_left_in;
   logic                   rdv_ff, rdv_in;
   lz77bw_pkg::status_type cp_status_ff, cp_status_in;
   logic                   cp_done_ff, cp_done_in;

   lz77bw_pkg::pack_cmd_type cmd;
   logic                     pk_ready;

   logic            acc;
   logic [7:0]      b;
   logic            hist_wr;
   logic [7:0]      hist_wdata;
   logic            issue;
   logic            append;
   logic [7:0]      rd_data;
   logic [23:0]     size_val;
   logic [7:0]      lit_dec;
   logic [23:0]     rem_dec;
   logic [CmpW-1:0] back_dist;
   logic            bad_ref;
   logic [CmpW:0]   src_sum;
   logic [CmpW:0]   src_wrap;
   logic            short;
   logic [8:0]      n;
   logic [23:0]     rem_after;
   logic [PtrW-1:0] hp_next;
   logic [PtrW-1:0] src_next;
   logic [CntW-1:0] bw_next;

   lz77bw_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_history (
      .clock   (clock),
      .wr_en   (hist_wr),
      .wr_addr (hp_ff),
      .wr_data (hist_wdata),
      .rd_en   (issue),
      .rd_addr (src_ff),
      .rd_data (rd_data)
   );

   lz77bw_pack #(.OUT_LANES(OUT_LANES)) u_pack (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .pk_ready (pk_ready),
      .rsp      (rsp_if)
   );

   assign req_if.ready = pk_ready && (phase_ff != lz77bw_pkg::PH_COPY);

   always_comb begin
      acc = req_if.valid && req_if.ready;
      b = req_if.in_byte;

      size_val = rem_ff;
      unique case (lit_ff[1:0])
         2'd0: size_val[7:0] = b;
         2'd1: size_val[15:8] = b;
         default: size_val[23:16] = b;
      endcase
      lit_dec = lit_ff - 8'd1;
      rem_dec = rem_ff - 24'd1;

      back_dist = CmpW'(b) + CmpW'(mlen_ff);
      bad_ref = (back_dist > CmpW'(bw_ff)) || (back_dist > CmpW'(HISTORY_DEPTH));
      src_sum = (CmpW+1)'(hp_ff) + (CmpW+1)'(HISTORY_DEPTH) - (CmpW+1)'(back_dist);
      src_wrap = (src_sum >= (CmpW+1)'(HISTORY_DEPTH)) ?
                 src_sum - (CmpW+1)'(HISTORY_DEPTH) : src_sum;
      short = {15'd0, mlen_ff} > rem_ff;
      n = short ? rem_ff[8:0] : mlen_ff;
      rem_after = rem_ff - {15'd0, n};

      hp_next = (hp_ff == PtrW'(HISTORY_DEPTH - 1)) ? '0 : hp_ff + PtrW'(1);
      src_next = (src_ff == PtrW'(HISTORY_DEPTH - 1)) ? '0 : src_ff + PtrW'(1);
      bw_next = (bw_ff == CntW'(HISTORY_DEPTH)) ? bw_ff : bw_ff + CntW'(1);

      append = (phase_ff == lz77bw_pkg::PH_COPY) && rdv_ff && pk_ready;
      issue = (phase_ff == lz77bw_pkg::PH_COPY) && (issue_left_ff != 9'd0) &&
              (!rdv_ff || append);

      phase_in = phase_ff;
      rem_in = rem_ff;
      lit_in = lit_ff;
      mlen_in = mlen_ff;
      hp_in = hp_ff;
      bw_in = bw_ff;
      src_in = src_ff;
      issue_left_in = issue_left_ff;
      append_left_in = append_left_ff;
      cp_status_in = cp_status_ff;
      cp_done_in = cp_done_ff;
      rdv_in = issue ? 1'b1 : (append ? 1'b0 : rdv_ff);

      hist_wr = 1'b0;
      hist_wdata = rd_data;
      cmd = '0;
      cmd.status = lz77bw_pkg::ST_OK;

      unique case (phase_ff)
         lz77bw_pkg::PH_VERSION: begin
            if (acc) begin
               if (b != lz77bw_pkg::VersionByte) begin
                  cmd.load = 1'b1;
                  cmd.status = lz77bw_pkg::ST_BAD_VERSION;
                  cmd.done = 1'b1;
                  phase_in = lz77bw_pkg::PH_DONE;
               end else begin
                  lit_in = 8'd0;
                  rem_in = 24'd0;
                  phase_in = lz77bw_pkg::PH_SIZE;
               end
            end
         end
         lz77bw_pkg::PH_SIZE: begin
            if (acc) begin
               rem_in = size_val;
               lit_in = lit_ff + 8'd1;
               if (lit_ff[1:0] == 2'd2) begin
                  lit_in = 8'd0;
                  if (size_val == 24'd0) begin
                     cmd.load = 1'b1;
                     cmd.done = 1'b1;
                     phase_in = lz77bw_pkg::PH_DONE;
                  end else begin
                     phase_in = lz77bw_pkg::PH_FLAG;
                  end
               end
            end
         end
         lz77bw_pkg::PH_FLAG: begin
            if (acc) begin
               if (b != 8'd0) begin
                  lit_in = b;
                  phase_in = lz77bw_pkg::PH_LITERAL;
               end else begin
                  phase_in = lz77bw_pkg::PH_MLEN;
               end
            end
         end
         lz77bw_pkg::PH_LITERAL: begin
            if (acc) begin
               hist_wr = 1'b1;
               hist_wdata = b;
               hp_in = hp_next;
               bw_in = bw_next;
               lit_in = lit_dec;
               rem_in = rem_dec;
               cmd.load = 1'b1;
               cmd.has_byte = 1'b1;
               cmd.data = b;
               if (rem_dec == 24'd0) begin
                  cmd.done = 1'b1;
                  cmd.status = (lit_dec != 8'd0) ? lz77bw_pkg::ST_OVERRUN : lz77bw_pkg::ST_OK;
                  lit_in = 8'd0;
                  phase_in = lz77bw_pkg::PH_DONE;
               end else if (lit_dec == 8'd0) begin
                  phase_in = lz77bw_pkg::PH_FLAG;
               end
            end
         end
         lz77bw_pkg::PH_MLEN: begin
            if (acc) begin
               mlen_in = {1'b0, b} + lz77bw_pkg::MinMatch;
               phase_in = lz77bw_pkg::PH_MOFF;
            end
         end
         lz77bw_pkg::PH_MOFF: begin
            if (acc) begin
               mlen_in = 9'd0;
               if (bad_ref) begin
                  cmd.load = 1'b1;
                  cmd.status = lz77bw_pkg::ST_BAD_REF;
                  cmd.done = 1'b1;
                  phase_in = lz77bw_pkg::PH_DONE;
               end else begin
                  src_in = src_wrap[PtrW-1:0];
                  issue_left_in = n;
                  append_left_in = n;
                  rem_in = rem_after;
                  cp_status_in = short ? lz77bw_pkg::ST_OVERRUN : lz77bw_pkg::ST_OK;
                  cp_done_in = (rem_after == 24'd0);
                  phase_in = lz77bw_pkg::PH_COPY;
               end
            end
         end
         lz77bw_pkg::PH_COPY: begin
            if (issue) begin
               src_in = src_next;
               issue_left_in = issue_left_ff - 9'd1;
            end
            if (append) begin
               hist_wr = 1'b1;
               hp_in = hp_next;
               bw_in = bw_next;
               append_left_in = append_left_ff - 9'd1;
               cmd.append = 1'b1;
               cmd.has_byte = 1'b1;
               cmd.data = rd_data;
               cmd.final_item = (append_left_ff == 9'd1);
               cmd.status = cp_status_ff;
               cmd.done = cp_done_ff;
               if (append_left_ff == 9'd1) begin
                  phase_in = cp_done_ff ? lz77bw_pkg::PH_DONE : lz77bw_pkg::PH_FLAG;
               end
            end
         end
         lz77bw_pkg::PH_DONE: begin
            phase_in = lz77bw_pkg::PH_DONE;
         end
         default: begin
            phase_in = lz77bw_pkg::PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lz77bw_pkg::PH_VERSION;
         rem_ff <= 24'd0;
         lit_ff <= 8'd0;
         mlen_ff <= 9'd0;
         hp_ff <= '0;
         bw_ff <= '0;
         issue_left_ff <= 9'd0;
         append_left_ff <= 9'd0;
         rdv_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rem_ff <= rem_in;
         lit_ff <= lit_in;
         mlen_ff <= mlen_in;
         hp_ff <= hp_in;
         bw_ff <= bw_in;
         issue_left_ff <= issue_left_in;
         append_left_ff <= append_left_in;
         rdv_ff <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      cp_status_ff <= cp_status_in;
      cp_done_ff <= cp_done_in;
   end

`ifndef SYNTHESIS
   a_no_read_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(issue && hist_wr && (src_ff == hp_ff)))
      else $error("history read and write hit the same entry");

   a_copy_counts: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lz77bw_pkg::PH_COPY) |->
         (append_left_ff == issue_left_ff + {8'd0, rdv_ff}))
      else $error("copy counters out of step");

   a_written_bound: assert property (@(posedge clock) disable iff (reset)
      bw_ff <= CntW'(HISTORY_DEPTH))
      else $error("written count beyond history depth");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lz77bw_pkg::PH_DONE) |=> (phase_ff == lz77bw_pkg::PH_DONE))
      else $error("left finished state without reset");
`endif

endmodule

/* rtl/lz77bw_history.sv */
module lz77bw_history #(
   parameter int HISTORY_DEPTH = lz77bw_pkg::HistoryDepthDef,
   localparam int PtrW = $clog2(HISTORY_DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [PtrW-1:0] wr_addr,
   input  logic [7:0]      wr_data,
   input  logic            rd_en,
   input  logic [PtrW-1:0] rd_addr,
   output logic [7:0]      rd_data
);

   logic [7:0] mem [HISTORY_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lz77bw_pack.sv */
module lz77bw_pack #(
   parameter int OUT_LANES = lz77bw_pkg::OutLanesDef
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lz77bw_pkg::pack_cmd_type cmd,
   output logic                     pk_ready,
   lz77bw_rsp_if.source             rsp
);

   logic                   pk_full_ff, pk_full_in;
   logic [3:0]             pk_cnt_ff, pk_cnt_in;
   logic [63:0]            pk_data_ff, pk_data_in;
   lz77bw_pkg::status_type pk_status_ff, pk_status_in;
   logic                   pk_done_ff, pk_done_in;
   logic                   pk_last_ff, pk_last_in;

   logic                   o_valid_ff, o_valid_in;
   logic [63:0]            o_data_ff;
   logic [3:0]             o_cnt_ff;
   lz77bw_pkg::status_type o_status_ff;
   logic                   o_done_ff;
   logic                   o_last_ff;

   logic        flush;
   logic [3:0]  base_cnt;
   logic [63:0] base_data;

   always_comb begin
      flush = pk_full_ff && (!o_valid_ff || rsp.ready);
      pk_ready = !pk_full_ff || flush;
      base_cnt = flush ? 4'd0 : pk_cnt_ff;
      base_data = (base_cnt == 4'd0) ? 64'd0 : pk_data_ff;

      pk_full_in = flush ? 1'b0 : pk_full_ff;
      pk_cnt_in = base_cnt;
      pk_data_in = pk_data_ff;
      pk_status_in = pk_status_ff;
      pk_done_in = pk_done_ff;
      pk_last_in = pk_last_ff;

      if (cmd.load) begin
         pk_data_in = {56'd0, cmd.has_byte ? cmd.data : 8'd0};
         pk_cnt_in = {3'd0, cmd.has_byte};
         pk_full_in = 1'b1;
         pk_status_in = cmd.status;
         pk_done_in = cmd.done;
         pk_last_in = 1'b1;
      end else if (cmd.append) begin
         pk_data_in = base_data;
         for (int lane = 0; lane < OUT_LANES; lane++) begin
            if (base_cnt == 4'(lane)) begin
               pk_data_in[8*lane +: 8] = cmd.data;
            end
         end
         pk_cnt_in = base_cnt + 4'd1;
         pk_full_in = cmd.final_item || (pk_cnt_in == 4'(OUT_LANES));
         pk_last_in = cmd.final_item;
         pk_status_in = cmd.final_item ? cmd.status : lz77bw_pkg::ST_OK;
         pk_done_in = cmd.final_item && cmd.done;
      end

      if (flush) begin
         o_valid_in = 1'b1;
      end else if (rsp.ready) begin
         o_valid_in = 1'b0;
      end else begin
         o_valid_in = o_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_full_ff <= 1'b0;
         pk_cnt_ff <= 4'd0;
         o_valid_ff <= 1'b0;
      end else begin
         pk_full_ff <= pk_full_in;
         pk_cnt_ff <= pk_cnt_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pk_data_ff <= pk_data_in;
      pk_status_ff <= pk_status_in;
      pk_done_ff <= pk_done_in;
      pk_last_ff <= pk_last_in;
      if (flush) begin
         o_data_ff <= pk_data_ff;
         o_cnt_ff <= pk_cnt_ff;
         o_status_ff <= pk_status_ff;
         o_done_ff <= pk_done_ff;
         o_last_ff <= pk_last_ff;
      end
   end

   assign rsp.valid = o_valid_ff;
   assign rsp.out_bytes = o_data_ff;
   assign rsp.byte_count = o_cnt_ff;
   assign rsp.status = o_status_ff;
   assign rsp.stream_done = o_done_ff;
   assign rsp.run_last = o_last_ff;

endmodule

/* tb/tb_lz77_byte_window_decompressor_unit.sv */
module tb_lz77_byte_window_decompressor_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HistDepth = lz77bw_pkg::HistoryDepthDef;
   localparam int Lanes = lz77bw_pkg::OutLanesDef;
   localparam int ItemTarget = 230;
   localparam int HoldCycles = 400;
   localparam int CycleLimit = 300000;

   typedef struct packed {
      logic [63:0]            data;
      logic [3:0]             count;
      lz77bw_pkg::status_type status;
      logic                   done;
      logic                   last;
   } out_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lz77bw_req_if req_ch ();
   lz77bw_rsp_if rsp_ch ();

   lz77_byte_window_decompressor_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic [7:0]   stream_bytes[$];
   logic [7:0]   pending_bytes[$];
   out_word_type expected_words[$];

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   mismatch_count = 0;
   int   cycle_count = 0;
   int   feed_pos = 0;
   int   gen_fill = 0;
   int   gen_total = 0;
   logic hold_rx = 1'b0;
   event hold_go;

   // decoder state
   lz77bw_pkg::phase_type dec_phase = lz77bw_pkg::PH_VERSION;
   int unsigned left_to_emit = 0;
   int unsigned run_left = 0;
   int unsigned size_idx = 0;
   int unsigned copy_len = 0;
   int unsigned wr_pos = 0;
   int unsigned window_fill = 0;
   logic [7:0]  window [HistDepth];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
   endtask

   function automatic void emit_words(input logic [7:0] data_q[$],
                                      input lz77bw_pkg::status_type st,
                                      input logic done);
      out_word_type w;
      int pos;
      int lane;
      pos = 0;
      do begin
         w = '0;
         lane = 0;
         while (lane < Lanes && pos < data_q.size()) begin
            w.data[8*lane +: 8] = data_q[pos];
            lane++;
            pos++;
         end
         w.count = 4'(lane);
         w.last = (pos >= data_q.size());
         if (w.last) begin
            w.status = st;
            w.done = done;
         end
         expected_words.push_back(w);
      end while (pos < data_q.size());
   endfunction

   function void store_byte(input logic [7:0] b);
      window[wr_pos] = b;
      wr_pos = (wr_pos + 1) % HistDepth;
      if (window_fill < HistDepth)
         window_fill++;
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      logic [7:0]             got_q[$];
      int unsigned            back_dist;
      int unsigned            n;
      int unsigned            src;
      lz77bw_pkg::status_type st;
      logic                   done;
      st = lz77bw_pkg::ST_OK;
      done = 1'b0;
      case (dec_phase)
         lz77bw_pkg::PH_VERSION: begin
            if (b != lz77bw_pkg::VersionByte) begin
               dec_phase = lz77bw_pkg::PH_DONE;
               emit_words(got_q, lz77bw_pkg::ST_BAD_VERSION, 1'b1);
            end else begin
               dec_phase = lz77bw_pkg::PH_SIZE;
               size_idx = 0;
               left_to_emit = 0;
            end
         end
         lz77bw_pkg::PH_SIZE: begin
            left_to_emit |= 32'(b) << (8 * size_idx);
            size_idx++;
            if (size_idx == 3) begin
               size_idx = 0;
               if (left_to_emit == 0) begin
                  dec_phase = lz77bw_pkg::PH_DONE;
                  emit_words(got_q, lz77bw_pkg::ST_OK, 1'b1);
               end else begin
                  dec_phase = lz77bw_pkg::PH_FLAG;
               end
            end
         end
         lz77bw_pkg::PH_FLAG: begin
            if (b != 8'd0) begin
               run_left = 32'(b);
               dec_phase = lz77bw_pkg::PH_LITERAL;
            end else begin
               dec_phase = lz77bw_pkg::PH_MLEN;
            end
         end
         lz77bw_pkg::PH_LITERAL: begin
            store_byte(b);
            got_q.push_back(b);
            run_left--;
            left_to_emit--;
            if (left_to_emit == 0) begin
               done = 1'b1;
               if (run_left != 0)
                  st = lz77bw_pkg::ST_OVERRUN;
               dec_phase = lz77bw_pkg::PH_DONE;
            end else if (run_left == 0) begin
               dec_phase = lz77bw_pkg::PH_FLAG;
            end
            emit_words(got_q, st, done);
         end
         lz77bw_pkg::PH_MLEN: begin
            copy_len = int'(b) + int'(lz77bw_pkg::MinMatch);
            dec_phase = lz77bw_pkg::PH_MOFF;
         end
         lz77bw_pkg::PH_MOFF: begin
            back_dist = int'(b) + copy_len;
            if (back_dist > window_fill || back_dist > HistDepth) begin
               dec_phase = lz77bw_pkg::PH_DONE;
               emit_words(got_q, lz77bw_pkg::ST_BAD_REF, 1'b1);
            end else begin
               n = copy_len;
               if (n > left_to_emit) begin
                  n = left_to_emit;
                  st = lz77bw_pkg::ST_OVERRUN;
               end
               src = (wr_pos + HistDepth - back_dist) % HistDepth;
               repeat (n) begin
                  got_q.push_back(window[src]);
                  store_byte(window[src]);
                  src = (src + 1) % HistDepth;
               end
               left_to_emit -= n;
               if (left_to_emit == 0) begin
                  done = 1'b1;
                  dec_phase = lz77bw_pkg::PH_DONE;
               end else begin
                  dec_phase = lz77bw_pkg::PH_FLAG;
               end
               emit_words(got_q, st, done);
            end
         end
         default: ;
      endcase
   endfunction

   function void note_output(input int n);
      gen_total += n;
      gen_fill = (gen_fill + n > HistDepth) ? HistDepth : gen_fill + n;
   endfunction

   function void plan_literals(input int f);
      stream_bytes.push_back(8'(f));
      repeat (f) stream_bytes.push_back(8'($urandom_range(255)));
      note_output(f);
   endfunction

   function void plan_match(input int len_code, input int off);
      stream_bytes.push_back(8'd0);
      stream_bytes.push_back(8'(len_code));
      stream_bytes.push_back(8'(off));
      note_output(len_code + 3);
   endfunction

   function void plan_random_token(input int budget);
      int room;
      int len_code;
      int len_max;
      if ($urandom_range(1) == 0) begin
         if ($urandom_range(24) == 0 && budget > 13)
            plan_literals($urandom_range(13, budget > 255 ? 255 : budget));
         else
            plan_literals($urandom_range(1, 12));
      end else begin
         room = gen_fill - 3;
         if ($urandom_range(9) == 0)
            len_max = room > 255 ? 255 : room;
         else
            len_max = room > 12 ? 12 : room;
         len_code = $urandom_range(0, len_max);
         plan_match(len_code, $urandom_range(0, room - len_code > 255 ? 255 : room - len_code));
      end
   endfunction

   task automatic feed_stream(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         pending_bytes.push_back(stream_bytes[feed_pos]);
         feed_pos++;
      end
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_ch.valid) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.in_byte <= 8'd0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            decode_byte(req_ch.in_byte);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.in_byte <= pending_bytes.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off
   always begin
      @(hold_go);
      hold_rx <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_rx <= 1'b0;
   end

   // monitor
   always @(posedge clock) begin : watch
      out_word_type want_word;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_ch.out_bytes, 64'd0);
         end else begin
            want_word = expected_words.pop_front();
            if (rsp_ch.out_bytes !== want_word.data)
               report_mismatch("out_bytes", rsp_ch.out_bytes, want_word.data);
            if (rsp_ch.byte_count !== want_word.count)
               report_mismatch("byte_count", 64'(rsp_ch.byte_count), 64'(want_word.count));
            if (rsp_ch.status !== want_word.status)
               report_mismatch("status", 64'(rsp_ch.status), 64'(want_word.status));
            if (rsp_ch.stream_done !== want_word.done)
               report_mismatch("stream_done", 64'(rsp_ch.stream_done), 64'(want_word.done));
            if (rsp_ch.run_last !== want_word.last)
               report_mismatch("run_last", 64'(rsp_ch.run_last), 64'(want_word.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int         ending;
      int         len_code;
      int         off;
      int         directed_len;
      int         rest;
      int         chunk;
      logic [23:0] size;

      ending = $urandom_range(17);
      if (ending == 0) begin
         // bad version
         if ($urandom_range(1) == 0)
            stream_bytes.push_back(8'($urandom_range(4, 255)));
         else
            stream_bytes.push_back(8'($urandom_range(0, 2)));
         directed_len = 1;
      end else if (ending == 1) begin
         // zero declared size
         stream_bytes.push_back(lz77bw_pkg::VersionByte);
         repeat (3) stream_bytes.push_back(8'd0);
         directed_len = 4;
      end else begin
         stream_bytes.push_back(8'd1);
         stream_bytes.push_back(8'h00);
         stream_bytes.push_back(8'd2);
         stream_bytes.push_back(8'hff);
         stream_bytes.push_back(8'h80);
         stream_bytes.push_back(8'd3);
         stream_bytes.push_back(8'h55);
         stream_bytes.push_back(8'haa);
         stream_bytes.push_back(8'h01);
         note_output(6);
         plan_match(0, 0);
         plan_match(0, 6);
         plan_match(5, 2);
         plan_literals(1);
         directed_len = stream_bytes.size() + 4;
         while (stream_bytes.size() < ItemTarget - 34)
            plan_random_token(ItemTarget - 34 - stream_bytes.size());

         if (ending <= 5) begin
            // exact end of stream
            plan_random_token(0);
            size = 24'(gen_total);
         end else if (ending <= 8) begin
            // literal run cut at the declared size
            len_code = $urandom_range(2, 20);
            plan_literals(len_code);
            size = 24'(gen_total - $urandom_range(1, len_code - 1));
         end else if (ending <= 11) begin
            // match cut at the declared size
            len_code = $urandom_range(1, gen_fill - 3 > 255 ? 255 : gen_fill - 3);
            off = gen_fill - 3 - len_code;
            plan_match(len_code, $urandom_range(0, off > 255 ? 255 : off));
            size = 24'(gen_total - $urandom_range(1, len_code + 2));
         end else if (ending <= 14) begin
            // back reference beyond the written history
            size = 24'(gen_total + $urandom_range(1, 1000));
            len_code = $urandom_range(255);
            off = gen_fill - len_code - 2;
            if (off > 255) begin
               len_code = 255;
               off = gen_fill - 257;
            end
            if (off < 0)
               off = 0;
            plan_match(len_code, $urandom_range(off, 255));
         end else begin
            // stream left open with a large declared size
            size = 24'(gen_total + $urandom_range(1, 24'hffffff - gen_total));
         end
         stream_bytes.push_front(size[23:16]);
         stream_bytes.push_front(size[15:8]);
         stream_bytes.push_front(size[7:0]);
         stream_bytes.push_front(lz77bw_pkg::VersionByte);
      end
      // trailing bytes after the stream has ended are ignored
      if (ending < 2) begin
         while (stream_bytes.size() < ItemTarget)
            stream_bytes.push_back(8'($urandom_range(255)));
      end else if (ending < 15) begin
         repeat (12) stream_bytes.push_back(8'($urandom_range(255)));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      feed_stream(directed_len, 0, 0);
      rest = stream_bytes.size() - directed_len;
      chunk = rest / 6;
      feed_stream(chunk, 0, 0);
      feed_stream(chunk, 81, 0);
      feed_stream(chunk, 0, 81);
      feed_stream(chunk, 26, 26);
      -> hold_go;
      feed_stream(chunk, 0, 0);
      while (expected_words.size() != 0) @(negedge clock);
      feed_stream(rest - 5 * chunk, 26, 26);
      while (expected_words.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
